### rtl/core/chol_pkg.sv
package chol_pkg;

    localparam int ORDER      = 16;
    localparam int IDX_W      = 4;
    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int CNT_W      = 6;
    localparam int SQRT_STEPS = ACC_W / 2;
    localparam int DIV_STEPS  = ACC_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER - 1);

    localparam logic [1:0] OP_WR_COV    = 2'd0;
    localparam logic [1:0] OP_WR_SAMPLE = 2'd1;
    localparam logic [1:0] OP_START     = 2'd2;

    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_SD   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_RD,
        S_F_LOAD,
        S_F_RDI,
        S_F_RDJ,
        S_F_MUL,
        S_F_SUB,
        S_F_END,
        S_F_SQRT,
        S_F_DWR,
        S_F_DIV,
        S_F_LWR,
        S_F_NEXT,
        S_O_CLR,
        S_O_RD,
        S_O_MUL,
        S_O_ACC,
        S_O_DIAG,
        S_O_DADD,
        S_O_MEAN,
        S_O_EMIT,
        S_E_EMIT
    } t_state;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_RD_IJ,
        DP_LOAD_ACC,
        DP_RD_IK,
        DP_RD_JK,
        DP_MUL_AB,
        DP_SUB,
        DP_SQRT_START,
        DP_SQRT_STEP,
        DP_DIAG_WR,
        DP_DIV_START,
        DP_DIV_STEP,
        DP_L_WR,
        DP_CLR_ACC,
        DP_MUL_ZS,
        DP_ADD,
        DP_MUL_DIAG,
        DP_ADD_MEAN,
        DP_EMIT,
        DP_EMIT_ERR
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic acc_le0;
        logic out_free;
    } t_status;

endpackage

### rtl/core/cholesky_correlated_gaussian_core.sv
// channel   | direction | handshake                   | payload
// s request | in        | i_s_tvalid / o_s_tready     | tuser op, tdata row/col/data
// m request | out       | o_m_tvalid / i_m_tready     | tdata index/value, tlast, tuser error
// cfg write | in        | i_cfg_wr_en, no wait        | i_cfg_addr, i_cfg_wdata
//
// load requests (ops 0, 1, 3) are accepted only while idle.
// a start request holds o_s_tready low for the whole run: each factor element
// accumulates its inner products, then uses the shared square root (and write)
// or divide (and write) unit; each result then accumulates its row. the
// single-port matrix memory sets the inner step.
// reset is synchronous; output stalls hold the run at its emit step.
module cholesky_correlated_gaussian_core import chol_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // row_index, col_index, data_value
    input  logic [1:0]        i_s_tuser,   // op
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // out_index, out_value, zero fill
    output logic              o_m_tlast,
    output logic              o_m_tuser,   // out_error
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_addr,
    input  logic [DATA_W-1:0] i_cfg_wdata
);

    t_cmd              cmd;
    t_status           status;
    logic              load_en;
    logic [IDX_W-1:0]  out_index;
    logic [DATA_W-1:0] out_value;

    chol_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_op    (i_s_tuser),
        .o_in_ready (o_s_tready),
        .o_load_en  (load_en),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    chol_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_load_en   (load_en),
        .i_load_op   (i_s_tuser),
        .i_load_row  (i_s_tdata[3:0]),
        .i_load_col  (i_s_tdata[7:4]),
        .i_load_data (i_s_tdata[39:8]),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_index (out_index),
        .o_out_value (out_value),
        .o_out_last  (o_m_tlast),
        .o_out_error (o_m_tuser)
    );

    assign o_m_tdata = {4'b0, out_value, out_index};

endmodule

### rtl/core/chol_dp.sv
module chol_dp import chol_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_load_en,
    input  logic [1:0]        i_load_op,
    input  logic [IDX_W-1:0]  i_load_row,
    input  logic [IDX_W-1:0]  i_load_col,
    input  logic [DATA_W-1:0] i_load_data,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_addr,
    input  logic [DATA_W-1:0] i_cfg_wdata,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [IDX_W-1:0]  o_out_index,
    output logic [DATA_W-1:0] o_out_value,
    output logic              o_out_last,
    output logic              o_out_error
);

    localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] D_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] D_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_sub(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    logic [DATA_W-1:0] r_mat [ORDER*ORDER];
    logic [DATA_W-1:0] r_mat_q;
    logic [DATA_W-1:0] r_smp [ORDER];
    logic [DATA_W-1:0] r_diag [ORDER];
    logic [DATA_W-1:0] r_mean, r_sd;
    logic [DATA_W-1:0] r_opa;
    logic [ACC_W-1:0]  r_prod, r_acc, n_acc;
    logic [ACC_W-1:0]  r_sx, r_sres, r_sbit;
    logic [ACC_W-1:0]  r_du;
    logic [DATA_W-1:0] r_drem, r_dd;
    logic              r_dneg;
    logic              r_valid;
    logic [IDX_W-1:0]  r_oidx;
    logic [DATA_W-1:0] r_oval;
    logic              r_olast, r_oerr;

    logic              row_ok, col_ok, mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, div_res, out_val;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic [ACC_W-1:0]  sq_rb, acc_shift;
    logic [DATA_W:0]   rem2;
    logic              div_ge;

    assign row_ok = {1'b0, i_load_row} < (IDX_W+1)'(ORDER);
    assign col_ok = {1'b0, i_load_col} < (IDX_W+1)'(ORDER);

    assign mem_we = (i_cmd.op == DP_L_WR) ||
                    (i_load_en && i_load_op == OP_WR_COV && row_ok && col_ok);
    assign mem_waddr = (i_cmd.op == DP_L_WR) ? {i_cmd.j, i_cmd.i} : {i_load_row, i_load_col};
    assign mem_wdata = (i_cmd.op == DP_L_WR) ? div_res : i_load_data;

    always_comb begin
        unique case (i_cmd.op)
            DP_RD_IJ: mem_raddr = {i_cmd.i, i_cmd.j};
            DP_RD_IK: mem_raddr = {i_cmd.i, i_cmd.k};
            default:  mem_raddr = {i_cmd.j, i_cmd.k};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mat[mem_waddr] <= mem_wdata;
        end
        r_mat_q <= r_mat[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_load_en && i_load_op == OP_WR_SAMPLE && row_ok) begin
            r_smp[i_load_row] <= i_load_data;
        end
        if (i_cmd.op == DP_DIAG_WR) begin
            r_diag[i_cmd.i] <= (|r_sres[ACC_W-1:DATA_W-1]) ? D_MAX : r_sres[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
            r_sd   <= DATA_W'(65536);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_MEAN: r_mean <= i_cfg_wdata;
                CFG_SD:   r_sd   <= i_cfg_wdata;
                default:  r_sd   <= r_sd;
            endcase
        end
    end

    // shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            DP_MUL_AB: begin
                mul_a = r_opa;
                mul_b = r_mat_q;
            end
            DP_MUL_ZS: begin
                mul_a = r_mat_q;
                mul_b = r_smp[i_cmd.k];
            end
            default: begin
                mul_a = r_diag[i_cmd.j];
                mul_b = r_smp[i_cmd.j];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_RD_JK) begin
            r_opa <= r_mat_q;
        end
        if (i_cmd.op == DP_MUL_AB || i_cmd.op == DP_MUL_ZS || i_cmd.op == DP_MUL_DIAG) begin
            r_prod <= ACC_W'(mul_a * mul_b);
        end
    end

    always_comb begin
        unique case (i_cmd.op)
            DP_LOAD_ACC: n_acc = {{(ACC_W-DATA_W-16){r_mat_q[DATA_W-1]}}, r_mat_q, 16'b0};
            DP_CLR_ACC:  n_acc = '0;
            DP_SUB:      n_acc = sat_sub(r_acc, r_prod);
            DP_ADD:      n_acc = sat_add(r_acc, r_prod);
            DP_ADD_MEAN: n_acc = sat_add(r_acc,
                                 {{(ACC_W-DATA_W-16){r_mean[DATA_W-1]}}, r_mean, 16'b0});
            default:     n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // square root, two radicand bits per step
    assign sq_rb = r_sres + r_sbit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_SQRT_START) begin
            r_sx   <= r_acc;
            r_sres <= '0;
            r_sbit <= {2'b01, {(ACC_W-2){1'b0}}};
        end else if (i_cmd.op == DP_SQRT_STEP) begin
            if (r_sx >= sq_rb) begin
                r_sx   <= r_sx - sq_rb;
                r_sres <= (r_sres >> 1) + r_sbit;
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end
    end

    // restoring divider on magnitudes
    assign rem2   = {r_drem, r_du[ACC_W-1]};
    assign div_ge = rem2 >= {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_DIV_START) begin
            r_dneg <= r_acc[ACC_W-1];
            r_du   <= r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
            r_drem <= '0;
            r_dd   <= r_diag[i_cmd.i];
        end else if (i_cmd.op == DP_DIV_STEP) begin
            r_drem <= div_ge ? DATA_W'(rem2 - {1'b0, r_dd}) : rem2[DATA_W-1:0];
            r_du   <= {r_du[ACC_W-2:0], div_ge};
        end
    end

    always_comb begin
        if (!r_dneg) begin
            div_res = (|r_du[ACC_W-1:DATA_W-1]) ? D_MAX : r_du[DATA_W-1:0];
        end else begin
            div_res = (r_du > {{(ACC_W-DATA_W){1'b0}}, D_MIN}) ? D_MIN
                    : (~r_du[DATA_W-1:0] + DATA_W'(1));
        end
    end

    assign acc_shift = $signed(r_acc) >>> 16;

    always_comb begin
        if (r_sd[DATA_W-1] || r_sd == '0) begin
            out_val = '0;
        end else if (acc_shift[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){acc_shift[ACC_W-1]}}) begin
            out_val = acc_shift[ACC_W-1] ? D_MIN : D_MAX;
        end else begin
            out_val = acc_shift[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.op == DP_EMIT || i_cmd.op == DP_EMIT_ERR) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_EMIT) begin
            r_oidx  <= i_cmd.j;
            r_oval  <= out_val;
            r_olast <= i_cmd.last;
            r_oerr  <= 1'b0;
        end else if (i_cmd.op == DP_EMIT_ERR) begin
            r_oidx  <= i_cmd.i;
            r_oval  <= '0;
            r_olast <= 1'b1;
            r_oerr  <= 1'b1;
        end
    end

    assign o_status.acc_le0  = r_acc[ACC_W-1] || (r_acc == '0);
    assign o_status.out_free = !r_valid || i_out_ready;

    assign o_out_valid = r_valid;
    assign o_out_index = r_oidx;
    assign o_out_value = r_oval;
    assign o_out_last  = r_olast;
    assign o_out_error = r_oerr;

endmodule

### rtl/core/chol_ctrl.sv
module chol_ctrl import chol_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    output logic       o_in_ready,
    output logic       o_load_en,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_i, r_j, r_k;
    logic [CNT_W-1:0]  r_cnt;
    logic              accept, start;
    logic              sqrt_done, div_done, row_last;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign start      = accept && i_in_op == OP_START;
    assign o_load_en  = accept;
    assign sqrt_done  = r_cnt == CNT_W'(SQRT_STEPS - 1);
    assign div_done   = r_cnt == CNT_W'(DIV_STEPS - 1);
    assign row_last   = r_j == LAST_IDX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_i <= '0;
                    r_j <= '0;
                end
            end
            S_F_LOAD: r_k <= r_i - IDX_W'(1);
            S_F_SUB: begin
                if (r_k != '0) r_k <= r_k - IDX_W'(1);
            end
            S_F_END: r_cnt <= '0;
            S_F_SQRT, S_F_DIV: r_cnt <= r_cnt + CNT_W'(1);
            S_F_NEXT: begin
                if (row_last) begin
                    r_i <= r_i + IDX_W'(1);
                    r_j <= (r_i == LAST_IDX) ? '0 : r_i + IDX_W'(1);
                end else begin
                    r_j <= r_j + IDX_W'(1);
                end
            end
            S_O_CLR: r_k <= '0;
            S_O_ACC: r_k <= r_k + IDX_W'(1);
            S_O_EMIT: begin
                if (i_status.out_free && !row_last) r_j <= r_j + IDX_W'(1);
            end
            default: r_k <= r_k;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_F_RD;
            S_F_RD:   n_state = S_F_LOAD;
            S_F_LOAD: n_state = (r_i == '0) ? S_F_END : S_F_RDI;
            S_F_RDI:  n_state = S_F_RDJ;
            S_F_RDJ:  n_state = S_F_MUL;
            S_F_MUL:  n_state = S_F_SUB;
            S_F_SUB:  n_state = (r_k == '0) ? S_F_END : S_F_RDI;
            S_F_END: begin
                if (r_i == r_j) begin
                    n_state = i_status.acc_le0 ? S_E_EMIT : S_F_SQRT;
                end else begin
                    n_state = S_F_DIV;
                end
            end
            S_F_SQRT: if (sqrt_done) n_state = S_F_DWR;
            S_F_DWR:  n_state = S_F_NEXT;
            S_F_DIV:  if (div_done) n_state = S_F_LWR;
            S_F_LWR:  n_state = S_F_NEXT;
            S_F_NEXT: n_state = (row_last && r_i == LAST_IDX) ? S_O_CLR : S_F_RD;
            S_O_CLR:  n_state = (r_j == '0) ? S_O_DIAG : S_O_RD;
            S_O_RD:   n_state = S_O_MUL;
            S_O_MUL:  n_state = S_O_ACC;
            S_O_ACC:  n_state = (r_k + IDX_W'(1) == r_j) ? S_O_DIAG : S_O_RD;
            S_O_DIAG: n_state = S_O_DADD;
            S_O_DADD: n_state = S_O_MEAN;
            S_O_MEAN: n_state = S_O_EMIT;
            S_O_EMIT: begin
                if (i_status.out_free) n_state = row_last ? S_IDLE : S_O_CLR;
            end
            S_E_EMIT: if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd.i    = r_i;
        o_cmd.j    = r_j;
        o_cmd.k    = r_k;
        o_cmd.last = row_last;
        unique case (r_state)
            S_F_RD:   o_cmd.op = DP_RD_IJ;
            S_F_LOAD: o_cmd.op = DP_LOAD_ACC;
            S_F_RDI:  o_cmd.op = DP_RD_IK;
            S_F_RDJ:  o_cmd.op = DP_RD_JK;
            S_F_MUL:  o_cmd.op = DP_MUL_AB;
            S_F_SUB:  o_cmd.op = DP_SUB;
            S_F_END: begin
                if (r_i == r_j) begin
                    o_cmd.op = i_status.acc_le0 ? DP_NOP : DP_SQRT_START;
                end else begin
                    o_cmd.op = DP_DIV_START;
                end
            end
            S_F_SQRT: o_cmd.op = DP_SQRT_STEP;
            S_F_DWR:  o_cmd.op = DP_DIAG_WR;
            S_F_DIV:  o_cmd.op = DP_DIV_STEP;
            S_F_LWR:  o_cmd.op = DP_L_WR;
            S_O_CLR:  o_cmd.op = DP_CLR_ACC;
            S_O_RD:   o_cmd.op = DP_RD_JK;
            S_O_MUL:  o_cmd.op = DP_MUL_ZS;
            S_O_ACC:  o_cmd.op = DP_ADD;
            S_O_DIAG: o_cmd.op = DP_MUL_DIAG;
            S_O_DADD: o_cmd.op = DP_ADD;
            S_O_MEAN: o_cmd.op = DP_ADD_MEAN;
            S_O_EMIT: o_cmd.op = i_status.out_free ? DP_EMIT : DP_NOP;
            S_E_EMIT: o_cmd.op = i_status.out_free ? DP_EMIT_ERR : DP_NOP;
            default:  o_cmd.op = DP_NOP;
        endcase
    end

endmodule

### verif/tb_cholesky_correlated_gaussian_core.sv
`timescale 1ns / 100ps

module tb_cholesky_correlated_gaussian_core;
    import chol_pkg::*;

    localparam int  SETTLE_CYC = 80;
    localparam longint CYC_LIMIT = 3_000_000;
    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    typedef struct {
        logic [3:0]  idx;
        logic [31:0] val;
        logic        last;
        logic        err;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        i_cfg_wr_en;
    logic        i_cfg_addr;
    logic [31:0] i_cfg_wdata;

    // predictor state
    longint cov_m [16][16];
    longint z_vec [16];
    longint l_diag [16];
    longint mean_q16;
    longint sd_q16;

    t_sample pending_samples[$];
    int      errors;
    int      n_starts;
    int      n_pivot_fail;
    int      n_results;
    int      n_reqs;
    int      idle_pct;
    int      stall_pct;
    longint  cycles;

    cholesky_correlated_gaussian_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic longint sat_add64(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic longint sat_sub64(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        return s[63:0];
    endfunction

    function automatic longint clamp32(longint v);
        if (v > MAX32) return MAX32;
        if (v < MIN32) return MIN32;
        return v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // factor in place, then queue L*Z + mean
    task automatic factor_and_correlate();
        longint acc;
        longint unsigned r;
        t_sample s;
        n_starts++;
        for (int i = 0; i < 16; i++) begin
            for (int j = i; j < 16; j++) begin
                acc = cov_m[i][j] * 65536;
                for (int k = i - 1; k >= 0; k--)
                    acc = sat_sub64(acc, cov_m[i][k] * cov_m[j][k]);
                if (i == j) begin
                    if (acc <= 0) begin
                        s.idx = 4'(i); s.val = '0; s.last = 1'b1; s.err = 1'b1;
                        pending_samples.push_back(s);
                        n_pivot_fail++;
                        return;
                    end
                    r = int_sqrt(acc);
                    l_diag[i] = (r > 64'h7FFF_FFFF) ? MAX32 : longint'(r);
                end else begin
                    cov_m[j][i] = clamp32(acc / l_diag[i]);
                end
            end
        end
        for (int j = 0; j < 16; j++) begin
            acc = 0;
            for (int k = 0; k < j; k++)
                acc = sat_add64(acc, cov_m[j][k] * z_vec[k]);
            acc = sat_add64(acc, l_diag[j] * z_vec[j]);
            acc = sat_add64(acc, mean_q16 * 65536);
            s.idx = 4'(j);
            s.val = (sd_q16 <= 0) ? 32'd0 : 32'(clamp32(acc >>> 16));
            s.last = (j == 15);
            s.err = 1'b0;
            pending_samples.push_back(s);
        end
    endtask

    task automatic send_req(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic [31:0] d);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = op;
        i_s_tdata = {d, c, r};
        do @(posedge i_clk); while (!o_s_tready);
        n_reqs++;
        case (op)
            OP_WR_COV:    cov_m[r][c] = longint'(signed'(d));
            OP_WR_SAMPLE: z_vec[r] = longint'(signed'(d));
            OP_START:     factor_and_correlate();
            default: ;
        endcase
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic addr, logic [31:0] v);
        drain();
        i_cfg_wr_en = 1'b1;
        i_cfg_addr = addr;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (addr == CFG_MEAN) mean_q16 = longint'(signed'(v));
        else sd_q16 = longint'(signed'(v));
    endtask

    function automatic logic [31:0] small_off();
        return 32'($signed($urandom_range(131071)) - 65536);
    endfunction

    function automatic logic [31:0] big_diag();
        return 32'($urandom_range(20, 300) * 65536 + $urandom_range(65535));
    endfunction

    task automatic load_matrix(bit identity);
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                if (c >= r)
                    send_req(OP_WR_COV, 4'(r), 4'(c),
                             identity ? ((r == c) ? 32'h0001_0000 : 32'h0)
                                      : ((r == c) ? big_diag() : small_off()));
    endtask

    // diagonally dominant so the factor always goes through
    task automatic boost_diagonal();
        for (int r = 0; r < 16; r++)
            send_req(OP_WR_COV, 4'(r), 4'(r), big_diag());
    endtask

    task automatic test_identity_extreme_samples();
        load_matrix(1'b1);
        send_req(OP_WR_SAMPLE, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_req(OP_WR_SAMPLE, 4'd1, 4'd0, 32'h8000_0000);
        send_req(OP_WR_SAMPLE, 4'd2, 4'd15, 32'hFFFF_FFFF);
        send_req(OP_WR_SAMPLE, 4'd3, 4'd0, 32'h0000_0001);
        for (int r = 4; r < 16; r++)
            send_req(OP_WR_SAMPLE, 4'(r), 4'(r), 32'($urandom));
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        drain();
    endtask

    task automatic test_pivot_failures();
        send_req(OP_WR_COV, 4'd0, 4'd0, 32'h0);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        drain();
        send_req(OP_WR_COV, 4'd0, 4'd0, 32'h0001_0000);
        send_req(OP_WR_COV, 4'd5, 4'd5, 32'hFFFF_0000);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        drain();
    endtask

    task automatic test_saturation();
        send_req(OP_WR_COV, 4'd0, 4'd0, 32'h7FFF_FFFF);
        send_req(OP_WR_COV, 4'd0, 4'd15, 32'h7FFF_FFFF);
        send_req(OP_WR_COV, 4'd15, 4'd15, 32'h7FFF_FFFF);
        send_req(OP_WR_COV, 4'd1, 4'd1, 32'h7FFF_FFFF);
        send_req(OP_WR_COV, 4'd1, 4'd2, 32'h8000_0000);
        send_req(OP_WR_SAMPLE, 4'd15, 4'd0, 32'h7FFF_FFFF);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        drain();
        // clear the large off-diagonal terms again
        send_req(OP_WR_COV, 4'd0, 4'd15, 32'h0);
        send_req(OP_WR_COV, 4'd1, 4'd2, 32'h0);
    endtask

    task automatic test_config_extremes();
        cfg_write(CFG_MEAN, 32'h7FFF_FFFF);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        cfg_write(CFG_MEAN, 32'h8000_0000);
        cfg_write(CFG_SD, 32'h0);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        cfg_write(CFG_SD, 32'h8000_0000);
        send_req(OP_START, 4'd0, 4'd0, 32'h0);
        cfg_write(CFG_SD, 32'h7FFF_FFFF);
        cfg_write(CFG_MEAN, 32'h0);
    endtask

    task automatic test_unknown_op();
        send_req(2'd3, 4'hF, 4'hF, 32'hFFFF_FFFF);
        send_req(2'd3, 4'h0, 4'h0, 32'h0);
        drain();
    endtask

    task automatic test_random_runs(int n_runs);
        int n_edits;
        logic [3:0] r;
        logic [3:0] c;
        for (int run = 0; run < n_runs; run++) begin
            n_edits = $urandom_range(3, 12);
            for (int e = 0; e < n_edits; e++) begin
                r = 4'($urandom);
                c = 4'($urandom);
                case ($urandom_range(9))
                    0, 1, 2: send_req(OP_WR_COV, r, r, big_diag());
                    3, 4, 5: send_req(OP_WR_COV, r, c, small_off());
                    6, 7:    send_req(OP_WR_SAMPLE, r, c,
                                      32'($signed($urandom_range(393216)) - 196608));
                    8:       send_req(2'd3, r, c, 32'($urandom));
                    default: send_req(4'($urandom_range(1)) == 0 ? OP_WR_COV : OP_WR_SAMPLE,
                                      r, r, 32'($urandom));
                endcase
            end
            send_req(OP_START, 4'($urandom), 4'($urandom), 32'($urandom));
            // repair after noise so later runs still factor
            if (pending_samples.size() > 0 && pending_samples[$].err) begin
                drain();
                boost_diagonal();
            end
        end
        drain();
    endtask

    task automatic set_idling(int snd, int rcv);
        drain();
        idle_pct = snd;
        stall_pct = rcv;
    endtask

    always @(negedge i_clk)
        i_m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk) begin
        t_sample s;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_results++;
            if (pending_samples.size() == 0) begin
                $error("result with nothing pending: index %0d", o_m_tdata[3:0]);
                errors++;
            end else begin
                s = pending_samples.pop_front();
                if (o_m_tdata[3:0] !== s.idx) begin
                    $error("out_index expected %0d actual %0d", s.idx, o_m_tdata[3:0]);
                    errors++;
                end
                if (o_m_tdata[35:4] !== s.val) begin
                    $error("out_value expected %h actual %h", s.val, o_m_tdata[35:4]);
                    errors++;
                end
                if (o_m_tlast !== s.last) begin
                    $error("out_last expected %0d actual %0d", s.last, o_m_tlast);
                    errors++;
                end
                if (o_m_tuser !== s.err) begin
                    $error("out_error expected %0d actual %0d", s.err, o_m_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        cycles = 0;
        errors = 0;
        n_starts = 0;
        n_pivot_fail = 0;
        n_results = 0;
        n_reqs = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = 1'b0;
        i_cfg_wdata = '0;
        for (int r = 0; r < 16; r++) begin
            z_vec[r] = 0;
            l_diag[r] = 0;
            for (int c = 0; c < 16; c++) cov_m[r][c] = 0;
        end
        mean_q16 = 0;
        sd_q16 = 65536;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_identity_extreme_samples();
        test_unknown_op();
        test_saturation();
        test_config_extremes();
        test_pivot_failures();
        boost_diagonal();

        set_idling(0, 0);
        test_random_runs(4);
        cfg_write(CFG_MEAN, 32'($signed($urandom_range(655360)) - 327680));
        set_idling(66, 0);
        test_random_runs(3);
        cfg_write(CFG_SD, 32'($signed($urandom_range(131072)) - 65536));
        set_idling(0, 66);
        test_random_runs(3);
        cfg_write(CFG_SD, 32'h0001_0000);
        set_idling(38, 38);
        test_random_runs(3);

        drain();
        if (pending_samples.size() != 0) begin
            $error("%0d results never arrived", pending_samples.size());
            errors++;
        end
        $display("covered %0d requests, %0d runs (%0d pivot failures), %0d results checked",
                 n_reqs, n_starts, n_pivot_fail, n_results);
        $display("mean and sd extremes, saturation, unknown op, four idle/stall mixes");
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### cholesky_correlated_gaussian_core.f
rtl/core/chol_pkg.sv
rtl/core/chol_dp.sv
rtl/core/chol_ctrl.sv
rtl/core/cholesky_correlated_gaussian_core.sv
verif/tb_cholesky_correlated_gaussian_core.sv
